// ----- rtl/core/murmur64a_stream_hash_top_macros.svh -----
// Assertion macros shared by the hash core RTL.
`ifndef MURMUR64A_STREAM_HASH_TOP_MACROS_SVH
`define MURMUR64A_STREAM_HASH_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled during reset
`define M64H_ASSERT_IMP(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("m64h assertion failed");

// Next-cycle implication, disabled during reset
`define M64H_ASSERT_NXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("m64h assertion failed");

`else

`define M64H_ASSERT_IMP(lbl, ck, rn, ante, cons)
`define M64H_ASSERT_NXT(lbl, ck, rn, ante, cons)

`endif

`endif

// ----- rtl/core/m64h_pkg.sv -----
// Constants, control types and mixing helpers of the 64-bit Murmur hash core.
package m64h_pkg;

    localparam logic [31:0] MUL_HI    = 32'hc6a4a793;
    localparam logic [31:0] MUL_LO    = 32'h5bd1e995;
    localparam int unsigned MIX_SHIFT = 47;

    // Byte address of the seed register on the configuration port
    localparam logic [3:0]  ADDR_SEED = 4'h0;

    // Controls for one issue slot of the shared 32x32 multiplier
    typedef struct packed {
        logic en;     // capture a new partial product
        logic hi_a;   // take the upper half of the operand
        logic hi_b;   // take the upper half of the multiplier constant
    } mul_ctl_t;

    // Xor a value with itself shifted right by the mix shift
    function automatic logic [63:0] fold_shift(input logic [63:0] v);
        fold_shift = v ^ (v >> MIX_SHIFT);
    endfunction

    // Keep the low bytes of a tail word, one to seven of them
    function automatic logic [63:0] tail_mask(input logic [2:0] cnt);
        logic [63:0] m;
        case (cnt)
            3'd1:    m = 64'h0000_0000_0000_00ff;
            3'd2:    m = 64'h0000_0000_0000_ffff;
            3'd3:    m = 64'h0000_0000_00ff_ffff;
            3'd4:    m = 64'h0000_0000_ffff_ffff;
            3'd5:    m = 64'h0000_00ff_ffff_ffff;
            3'd6:    m = 64'h0000_ffff_ffff_ffff;
            3'd7:    m = 64'h00ff_ffff_ffff_ffff;
            default: m = 64'h0;
        endcase
        tail_mask = m;
    endfunction

endpackage

// ----- rtl/core/murmur64a_stream_hash_top.sv -----
// Top level of the 64-bit Murmur stream hash core: sequencer, state and APB seed register.
// Each 64-bit product is built on one shared 32x32 multiplier from three partial products.
// An item is accepted in IDLE and then takes one product per state: a full word KEY1, KEY2, HASH,
// a tail word HASH, plus INIT when first_word loads the seed and FIN when last_word finalizes.
// One item at a time; the digest sits in an output register, so the next item is taken meanwhile.
// Reset clears the sequencer, the running hash, the seed and the output valid; no clearing pass.
module murmur64a_stream_hash_top (
    input  logic        clk,
    input  logic        rst_n,
    // Input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [63:0] data_word,
    input  logic [3:0]  byte_count,
    input  logic        first_word,
    input  logic        last_word,
    input  logic [31:0] message_length,
    // Output channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] digest,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    `include "murmur64a_stream_hash_top_macros.svh"

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_INIT = 6'b000010,
        ST_KEY1 = 6'b000100,
        ST_KEY2 = 6'b001000,
        ST_HASH = 6'b010000,
        ST_FIN  = 6'b100000
    } state_t;

    state_t             state_reg, state_next;
    logic [1:0]         step_reg, step_next;
    logic [63:0]        h_reg, h_next;
    logic [63:0]        seed_reg;
    logic               out_valid_reg, out_valid_next;
    logic [63:0]        opnd_reg, opnd_next;
    logic [63:0]        acc_reg, acc_next;
    logic [63:0]        word_reg, word_next;
    logic [3:0]         count_reg, count_next;
    logic               last_reg, last_next;
    logic [63:0]        digest_reg, digest_next;

    logic               accept;
    logic               busy;
    logic               mul_done;
    logic               out_free;
    logic               cfg_write;
    logic [63:0]        prod;
    logic [63:0]        mul_res;
    m64h_pkg::mul_ctl_t mul_ctl;

    // Dispatch inputs and results
    logic [63:0]        d_h;
    logic [63:0]        d_word;
    logic [3:0]         d_count;
    logic               d_last;
    state_t             d_state;
    logic [63:0]        d_opnd;

    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign busy      = (state_reg != ST_IDLE);
    assign mul_done  = busy && (step_reg == 2'd3);
    assign out_free  = !out_valid_reg || !out_stall;
    assign cfg_write = psel && penable && pwrite && pready;

    // Issue partial products: low*low, high*low, low*high
    always_comb
    begin
        mul_ctl.en   = busy && (step_reg != 2'd3);
        mul_ctl.hi_a = (step_reg == 2'd1);
        mul_ctl.hi_b = (step_reg == 2'd2);
    end

    m64h_mul u_mul (
        .clk  (clk),
        .ctl  (mul_ctl),
        .opnd (opnd_reg),
        .prod (prod)
    );

    // Add the shifted cross product onto the low product
    assign mul_res = acc_reg + {prod[31:0], 32'h0};

    // Pick the work for the current hash: key mix, tail fold, finalize or nothing
    always_comb
    begin
        d_h     = (state_reg == ST_INIT) ? (seed_reg ^ mul_res) : h_reg;
        d_word  = (state_reg == ST_IDLE) ? data_word : word_reg;
        d_count = (state_reg == ST_IDLE) ? byte_count : count_reg;
        d_last  = (state_reg == ST_IDLE) ? last_word : last_reg;
        if (d_count[3])
        begin
            d_state = ST_KEY1;
            d_opnd  = d_word;
        end
        else if (d_count[2:0] != 3'd0)
        begin
            d_state = ST_HASH;
            d_opnd  = d_h ^ (d_word & m64h_pkg::tail_mask(d_count[2:0]));
        end
        else if (d_last)
        begin
            d_state = ST_FIN;
            d_opnd  = m64h_pkg::fold_shift(d_h);
        end
        else
        begin
            d_state = ST_IDLE;
            d_opnd  = opnd_reg;
        end
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        h_next         = h_reg;
        opnd_next      = opnd_reg;
        acc_next       = acc_reg;
        word_next      = word_reg;
        count_next     = count_reg;
        last_next      = last_reg;
        digest_next    = digest_reg;
        out_valid_next = out_valid_reg && out_stall;

        // Accumulate partial products while a product is in flight
        if (busy)
        begin
            if (step_reg == 2'd1)
            begin
                acc_next = prod;
            end
            else if (step_reg == 2'd2)
            begin
                acc_next = mul_res;
            end
            if (step_reg != 2'd3)
            begin
                step_next = step_reg + 2'd1;
            end
            else
            begin
                step_next = 2'd0;
            end
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    word_next  = data_word;
                    count_next = byte_count;
                    last_next  = last_word;
                    if (first_word)
                    begin
                        state_next = ST_INIT;
                        opnd_next  = {32'h0, message_length};
                    end
                    else
                    begin
                        state_next = d_state;
                        opnd_next  = d_opnd;
                    end
                end
            end
            ST_INIT:
            begin
                if (mul_done)
                begin
                    h_next     = seed_reg ^ mul_res;
                    state_next = d_state;
                    opnd_next  = d_opnd;
                end
            end
            ST_KEY1:
            begin
                if (mul_done)
                begin
                    state_next = ST_KEY2;
                    opnd_next  = m64h_pkg::fold_shift(mul_res);
                end
            end
            ST_KEY2:
            begin
                if (mul_done)
                begin
                    state_next = ST_HASH;
                    opnd_next  = h_reg ^ mul_res;
                end
            end
            ST_HASH:
            begin
                if (mul_done)
                begin
                    h_next = mul_res;
                    if (last_reg)
                    begin
                        state_next = ST_FIN;
                        opnd_next  = m64h_pkg::fold_shift(mul_res);
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_FIN:
            begin
                if (mul_done)
                begin
                    if (out_free)
                    begin
                        digest_next    = m64h_pkg::fold_shift(mul_res);
                        out_valid_next = 1'b1;
                        state_next     = ST_IDLE;
                    end
                    else
                    begin
                        // Hold the finished product until the output register drains
                        step_next = 2'd3;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                step_next  = 2'd0;
            end
        endcase
    end

    // Control state and running hash
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= 2'd0;
            h_reg         <= 64'h0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            h_reg         <= h_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath payload
    always_ff @(posedge clk)
    begin
        opnd_reg   <= opnd_next;
        acc_reg    <= acc_next;
        word_reg   <= word_next;
        count_reg  <= count_next;
        last_reg   <= last_next;
        digest_reg <= digest_next;
    end

    // Seed register write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= 64'h0;
        end
        else if (cfg_write && (paddr == m64h_pkg::ADDR_SEED))
        begin
            seed_reg <= pwdata;
        end
    end

    assign prdata    = (paddr == m64h_pkg::ADDR_SEED) ? seed_reg : 64'h0;
    assign pready    = 1'b1;
    assign out_valid = out_valid_reg;
    assign digest    = digest_reg;

    `M64H_ASSERT_IMP(a_out_from_fin, clk, rst_n, $rose(out_valid_reg), $past(state_reg == ST_FIN))
    `M64H_ASSERT_IMP(a_idle_step_zero, clk, rst_n, state_reg == ST_IDLE, step_reg == 2'd0)
    `M64H_ASSERT_NXT(a_first_loads_seed, clk, rst_n, accept && first_word, state_reg == ST_INIT)
    `M64H_ASSERT_NXT(a_fin_emits, clk, rst_n, mul_done && (state_reg == ST_FIN) && out_free, out_valid_reg)

endmodule

// ----- rtl/core/m64h_mul.sv -----
// Shared 32x32 multiplier against a half of the Murmur constant, registered product.
module m64h_mul (
    input  logic                clk,
    input  m64h_pkg::mul_ctl_t  ctl,
    input  logic [63:0]         opnd,
    output logic [63:0]         prod
);

    logic [31:0] a_half;
    logic [31:0] b_half;
    logic [63:0] prod_next;
    logic [63:0] prod_reg;

    // Select operand halves for this slot
    assign a_half    = ctl.hi_a ? opnd[63:32] : opnd[31:0];
    assign b_half    = ctl.hi_b ? m64h_pkg::MUL_HI : m64h_pkg::MUL_LO;
    assign prod_next = {32'h0, a_half} * {32'h0, b_half};

    // Capture the partial product, hold otherwise
    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

// ----- tb/sv/murmur64a_digest_checker.sv -----
// Checker that predicts Murmur64A digests from observed transfers and compares them.
module murmur64a_digest_checker #(
    parameter logic [3:0] SEED_ADDR = m64h_pkg::ADDR_SEED
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [63:0] data_word,
    input  logic [3:0]  byte_count,
    input  logic        first_word,
    input  logic        last_word,
    input  logic [31:0] message_length,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [63:0] digest,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    input  logic        pready,
    output int          fail_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0] MIX_MUL      = {m64h_pkg::MUL_HI, m64h_pkg::MUL_LO};
    localparam int          FULL_WORD    = 8;
    localparam int          REPORT_LIMIT = 10;

    logic [63:0] seed_reg;
    logic [63:0] chain_hash;
    logic [63:0] digests_due[$];
    int          shown;

    // Xor a value with itself shifted down by the mix distance
    function automatic logic [63:0] xorshift(input logic [63:0] v);
        return v ^ (v >> m64h_pkg::MIX_SHIFT);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic [63:0] acc;
        logic [63:0] k;
        int          errs;
        if (!rst_n)
        begin
            seed_reg   = '0;
            chain_hash = '0;
            digests_due.delete();
            shown      = 0;
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            errs = fail_count;

            // Retire a result transfer against the oldest prediction
            if (out_valid && !out_stall)
            begin
                if (digests_due.size() == 0)
                begin
                    errs++;
                    if (shown < REPORT_LIMIT)
                        $display("unexpected digest %h at %0t", digest, $time);
                    shown++;
                end
                else
                begin
                    k = digests_due.pop_front();
                    if (digest !== k)
                    begin
                        errs++;
                        if (shown < REPORT_LIMIT)
                            $display("digest mismatch at %0t: expected %h, got %h",
                                     $time, k, digest);
                        shown++;
                    end
                end
            end

            // Track seed register writes
            if (psel && penable && pwrite && pready && paddr == SEED_ADDR)
                seed_reg = pwdata;

            // Absorb an input transfer into the running hash
            if (in_valid && !in_stall)
            begin
                acc = first_word ? (seed_reg ^ ({32'd0, message_length} * MIX_MUL))
                                 : chain_hash;
                if (byte_count >= FULL_WORD)
                begin
                    k   = xorshift(data_word * MIX_MUL) * MIX_MUL;
                    acc = (acc ^ k) * MIX_MUL;
                end
                else if (byte_count != 0)
                begin
                    // Keep only the valid tail bytes
                    k   = (64'd1 << (8 * byte_count[2:0])) - 64'd1;
                    acc = (acc ^ (data_word & k)) * MIX_MUL;
                end
                chain_hash = acc;
                if (last_word)
                    digests_due.push_back(xorshift(xorshift(acc) * MIX_MUL));
            end

            fail_count <= errs;
            pending    <= digests_due.size();
        end
    end

endmodule

// ----- tb/sv/tb_murmur64a_stream_hash_top.sv -----
// Testbench top for the Murmur64A stream hash: stimulus, seed writes, flow control and verdict.
module tb_murmur64a_stream_hash_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [3:0] SEED_ADDR       = m64h_pkg::ADDR_SEED;
    localparam int         ITEMS_PER_PHASE = 260;
    localparam int         LONG_HOLD       = 400;
    localparam int         SETTLE          = 40;
    localparam int         MAX_GAP         = 8;
    localparam int         RESET_CYCLES    = 12;
    localparam int         HOLD_AFTER      = 60;
    localparam int         CYCLE_LIMIT     = 500000;
    localparam logic [63:0] ALL_ONES       = '1;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [63:0] data_word;
    logic [3:0]  byte_count;
    logic        first_word;
    logic        last_word;
    logic [31:0] message_length;
    logic        out_valid;
    logic        out_stall;
    logic [63:0] digest;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    int fail_count;
    int pending;
    int cycle_count = 0;
    int burst_left  = 0;
    int items_sent  = 0;
    bit hold_req    = 1'b0;
    bit hold_done   = 1'b0;

    murmur64a_stream_hash_top i_dut (.*);

    murmur64a_digest_checker #(.SEED_ADDR(SEED_ADDR)) i_checker (.*);

    // Generate the clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Stall the result channel: random segments plus one long hold-off
    initial
    begin
        int mode;
        int span;
        out_stall <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else
            begin
                mode = $urandom_range(0, 3);
                span = $urandom_range(4, 64);
                repeat (span)
                begin
                    out_stall <= (mode == 0) ? 1'b0 : ($urandom_range(0, 3) < mode);
                    @(posedge clk);
                end
            end
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Offer one item, opening a new burst after a random gap when needed
    task automatic put_item(input logic [63:0] w, input logic [3:0] cnt,
                            input logic is_first, input logic is_last,
                            input logic [31:0] len);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, MAX_GAP);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        in_valid       <= 1'b1;
        data_word      <= w;
        byte_count     <= cnt;
        first_word     <= is_first;
        last_word      <= is_last;
        message_length <= len;
        // Hold the payload until the transfer happens
        do @(posedge clk); while (in_stall);
        burst_left--;
        items_sent++;
    endtask

    // Send a message of nbytes random bytes, optionally broken in shape
    task automatic send_message(input int nbytes, input bit with_first, input bit with_last,
                                input bit short_mid);
        int          left;
        int          cnt;
        bit          fw;
        logic [31:0] len;
        len  = ($urandom_range(0, 9) == 0) ? $urandom : nbytes;
        left = nbytes;
        fw   = with_first;
        if (nbytes == 0)
            put_item(rand64(), 4'd0, with_first, with_last, len);
        while (left > 0)
        begin
            cnt = (left > 8) ? 8 : left;
            if (short_mid && left > 8 && $urandom_range(0, 2) == 0)
                cnt = $urandom_range(1, 7);
            left -= cnt;
            // Occasionally mark a full word with an oversized count
            if (cnt == 8 && $urandom_range(0, 19) == 0)
                cnt = $urandom_range(9, 15);
            put_item(rand64(), 4'(cnt), fw, with_last && left == 0, len);
            fw = 1'b0;
        end
    endtask

    // Wait until every digest is back and the core has gone quiet
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_seed(input logic [63:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= SEED_ADDR;
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Mostly well-formed messages, some broken ones and raw noise
    task automatic run_random(input int target, input bit with_hold);
        int start;
        int r;
        int sz;
        int nb;
        start = items_sent;
        while (items_sent < start + target)
        begin
            r  = $urandom_range(0, 99);
            sz = $urandom_range(0, 99);
            nb = (sz < 80) ? $urandom_range(0, 24)
               : (sz < 97) ? $urandom_range(25, 80) : $urandom_range(81, 300);
            if (r < 75)
                send_message(nb, 1'b1, 1'b1, 1'b0);
            else if (r < 82)
                send_message(nb, 1'b0, 1'b1, 1'b0);
            else if (r < 88)
                send_message(nb, 1'b1, 1'b0, 1'b0);
            else if (r < 93)
                send_message(nb, 1'b1, 1'b1, 1'b1);
            else
                put_item(rand64(), 4'($urandom_range(0, 15)), 1'($urandom), 1'($urandom),
                         $urandom);
            if (with_hold && items_sent >= start + HOLD_AFTER)
                hold_req = 1'b1;
        end
        // Close with an empty message so the phase ends on a digest
        put_item(rand64(), 4'd0, 1'b1, 1'b1, 32'd0);
    endtask

    initial
    begin
        in_valid       <= 1'b0;
        data_word      <= '0;
        byte_count     <= '0;
        first_word     <= 1'b0;
        last_word      <= 1'b0;
        message_length <= '0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= SEED_ADDR;
        pwdata         <= '0;
        rst_n          <= 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: continue from the reset hash, then edge cases under an all-ones seed
        put_item(64'd0, 4'd8, 1'b0, 1'b1, 32'd0);
        drain();
        write_seed(ALL_ONES);
        put_item(rand64(), 4'd0, 1'b1, 1'b1, 32'd0);
        put_item(ALL_ONES, 4'd8, 1'b1, 1'b1, 32'd8);
        put_item(ALL_ONES, 4'd15, 1'b1, 1'b1, 32'd8);
        put_item(rand64(), 4'd9, 1'b1, 1'b1, 32'hFFFF_FFFF);
        put_item(64'd0, 4'd8, 1'b1, 1'b1, 32'hFFFF_FFFF);
        for (int n = 1; n < 8; n++)
            put_item(ALL_ONES, 4'(n), 1'b1, 1'b1, 32'(n));
        // Short word in the middle of a message
        put_item(64'h0123_4567_89ab_cdef, 4'd8, 1'b1, 1'b0, 32'd19);
        put_item(ALL_ONES, 4'd3, 1'b0, 1'b0, 32'd0);
        put_item(rand64(), 4'd8, 1'b0, 1'b1, 32'd0);
        // Zero-byte last word after a full word
        put_item(rand64(), 4'd8, 1'b1, 1'b0, 32'd8);
        put_item(rand64(), 4'd0, 1'b0, 1'b1, 32'd0);
        // Continue past a finished message without a new first word
        put_item(rand64(), 4'd5, 1'b0, 1'b0, 32'd0);
        put_item(rand64(), 4'd0, 1'b0, 1'b1, 32'd0);
        drain();

        write_seed('0);
        run_random(ITEMS_PER_PHASE, 1'b1);
        drain();

        write_seed(rand64());
        run_random(ITEMS_PER_PHASE, 1'b0);
        drain();

        write_seed(64'h8000_0000_0000_0001);
        run_random(ITEMS_PER_PHASE, 1'b0);
        drain();

        if (fail_count == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
